### src/spk_pkg.sv
`timescale 1ns / 1ps
package spk_pkg;

  localparam int ROUNDS      = 27;
  localparam int RK_IDX_W    = $clog2(ROUNDS);
  localparam int WORD_W      = 32;
  localparam int BYTE_W      = 8;
  localparam int POS_W       = 3;
  localparam int CFG_IDX_W   = 2;
  localparam int QUEUE_DEPTH = 2;
  localparam int Q_IDX_W     = $clog2(QUEUE_DEPTH);
  localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

  typedef logic [WORD_W-1:0] word_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    KEY_WORD_0 = 2'd0,
    KEY_WORD_1 = 2'd1,
    KEY_WORD_2 = 2'd2,
    KEY_WORD_3 = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    word_t w3;
    word_t w2;
    word_t w1;
    word_t w0;
  } key_t;

  // One queued byte, already classified by the front end
  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              restart;
    logic              new_block;
    logic [POS_W-1:0]  pos;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  function automatic word_t rotr8(input word_t v);
    return {v[7:0], v[WORD_W-1:8]};
  endfunction

  function automatic word_t rotl3(input word_t v);
    return {v[WORD_W-4:0], v[WORD_W-1:WORD_W-3]};
  endfunction

endpackage

### src/spk_front.sv
`timescale 1ns / 1ps
module spk_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [spk_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [spk_pkg::WORD_W-1:0]    cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [spk_pkg::BYTE_W-1:0]    in_data_byte,
  input  logic                          in_restart,
  input  spk_pkg::queue_status_t        q_status,
  output logic                          q_push,
  output spk_pkg::item_t                q_item,
  output spk_pkg::key_t                 key
);
  import spk_pkg::*;

  key_t             key_r;
  logic [POS_W-1:0] pos_r;
  logic [POS_W-1:0] pos_nxt;
  logic             accept;

  assign in_stall = q_status.full;
  assign accept   = in_valid && !q_status.full;
  assign q_push   = accept;
  assign key      = key_r;

  // Classify the byte: its block position and whether a new block is due
  always_comb begin
    q_item.data      = in_data_byte;
    q_item.restart   = in_restart;
    q_item.pos       = in_restart ? '0 : pos_r;
    q_item.new_block = in_restart || (pos_r == '0);
    pos_nxt          = q_item.pos + POS_W'(1);
  end

  // Hold key words and advance the byte position per beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= '0;
      pos_r <= '0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_reg_t'(cfg_index))
          KEY_WORD_0: key_r.w0 <= cfg_wdata;
          KEY_WORD_1: key_r.w1 <= cfg_wdata;
          KEY_WORD_2: key_r.w2 <= cfg_wdata;
          KEY_WORD_3: key_r.w3 <= cfg_wdata;
          default:    key_r    <= key_r;
        endcase
      end
      if (accept) begin
        pos_r <= pos_nxt;
      end
    end
  end

endmodule

### src/spk_queue.sv
`timescale 1ns / 1ps
module spk_queue (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  spk_pkg::item_t         push_item,
  input  logic                   pop,
  output spk_pkg::item_t         head_item,
  output spk_pkg::queue_status_t status
);
  import spk_pkg::*;

  item_t              slot_r [QUEUE_DEPTH];
  logic [Q_IDX_W-1:0] wr_ptr_r;
  logic [Q_IDX_W-1:0] rd_ptr_r;
  logic [Q_CNT_W-1:0] count_r;
  logic               do_push;
  logic               do_pop;

  assign status.full  = (count_r == Q_CNT_W'(QUEUE_DEPTH));
  assign status.empty = (count_r == '0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign head_item    = slot_r[rd_ptr_r];

  // Store the incoming beat
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == Q_IDX_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + Q_IDX_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == Q_IDX_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + Q_IDX_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + Q_CNT_W'(1);
        2'b01:   count_r <= count_r - Q_CNT_W'(1);
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

### src/spk_back.sv
`timescale 1ns / 1ps
module spk_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  spk_pkg::key_t              key,
  input  spk_pkg::queue_status_t     q_status,
  input  spk_pkg::item_t             q_item,
  output logic                       q_pop,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [spk_pkg::BYTE_W-1:0] out_result_byte
);
  import spk_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_OUT
  } state_t;

  state_t              state_r;
  logic [RK_IDX_W-1:0] round_r;
  logic                expand_r;
  word_t               x_r;
  word_t               y_r;
  word_t               rk_r;
  word_t               l0_r;
  word_t               l1_r;
  word_t               l2_r;
  word_t               rk_bank_r [ROUNDS];
  logic [BYTE_W-1:0]   data_r;
  logic [POS_W-1:0]    pos_r;
  logic                out_valid_r;
  logic [BYTE_W-1:0]   out_byte_r;

  word_t               round_key;
  word_t               x_nxt;
  word_t               y_nxt;
  word_t               l_nxt;
  word_t               rk_nxt;
  logic                out_free;
  logic                out_load;
  logic [2*WORD_W-1:0] fb;

  assign out_valid       = out_valid_r;
  assign out_result_byte = out_byte_r;
  assign out_free        = !out_valid_r || !out_stall;
  assign fb              = {x_r, y_r};
  assign q_pop           = !q_status.empty && (state_r == ST_IDLE) &&
                           (q_item.new_block || out_free);
  // A result beat is loaded straight from the queue or after the rounds
  assign out_load        = ((state_r == ST_IDLE) && q_pop && !q_item.new_block) ||
                           ((state_r == ST_OUT) && out_free);

  // One Speck round, with the key schedule step alongside while expanding
  always_comb begin
    round_key = expand_r ? rk_r : rk_bank_r[round_r];
    x_nxt     = (rotr8(x_r) + y_r) ^ round_key;
    y_nxt     = rotl3(y_r) ^ x_nxt;
    l_nxt     = (rotr8(l0_r) + rk_r) ^ {{(WORD_W-RK_IDX_W){1'b0}}, round_r};
    rk_nxt    = rotl3(rk_r) ^ l_nxt;
  end

  // Keep the round keys as they are produced
  always_ff @(posedge clk) begin
    if (state_r == ST_RUN && expand_r) begin
      rk_bank_r[round_r] <= rk_r;
    end
  end

  // Sequence the item, run the rounds and load the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      expand_r    <= 1'b0;
      x_r         <= '0;
      y_r         <= '0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (q_pop) begin
            if (q_item.new_block) begin
              data_r  <= q_item.data;
              pos_r   <= q_item.pos;
              round_r <= '0;
              state_r <= ST_RUN;
              if (q_item.restart) begin
                x_r      <= key.w1 ^ key.w3;
                y_r      <= key.w0 ^ key.w2;
                rk_r     <= key.w0;
                l0_r     <= key.w1;
                l1_r     <= key.w2;
                l2_r     <= key.w3;
                expand_r <= 1'b1;
              end else begin
                expand_r <= 1'b0;
              end
            end else begin
              out_byte_r <= q_item.data ^ fb[q_item.pos*BYTE_W +: BYTE_W];
            end
          end
        end
        ST_RUN: begin
          x_r     <= x_nxt;
          y_r     <= y_nxt;
          round_r <= round_r + RK_IDX_W'(1);
          if (expand_r) begin
            rk_r <= rk_nxt;
            l0_r <= l1_r;
            l1_r <= l2_r;
            l2_r <= l_nxt;
          end
          if (round_r == RK_IDX_W'(ROUNDS - 1)) begin
            state_r <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            out_byte_r <= data_r ^ fb[pos_r*BYTE_W +: BYTE_W];
            expand_r   <= 1'b0;
            state_r    <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

### src/speck64_ofb_stream_xor_core.sv
`timescale 1ns / 1ps
// Speck64/128 output-feedback keystream XOR over a byte stream.
// Input channel in_*: one data byte per beat, in_restart marks the first byte
// of a new buffer. Output channel out_*: one result byte per input beat, in
// order. Both use valid/stall; a beat moves when valid is high and stall low.
// Configuration: cfg_wr_en writes cfg_wdata into key word cfg_index (0..3);
// the key words are picked up only by the next restart beat.
// A front end classifies each beat (block position, new block due) into a
// two-entry queue; the back end runs one Speck round per cycle.
// A byte that opens a block (restart, or every eighth byte) waits for the 27
// rounds; a restart also expands the round keys during those same rounds.
// Other bytes go straight from the queue into the output register when it is free.
// The back end has a single round unit and takes no new byte from the queue
// while it runs the rounds of a block.
// Reset (rst_n low, synchronous) clears the key words, feedback block, byte
// position, queue and output valid. While out_stall is high the result byte
// holds; the queue then fills and in_stall rises.
module speck64_ofb_stream_xor_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [spk_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [spk_pkg::WORD_W-1:0]    cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [spk_pkg::BYTE_W-1:0]    in_data_byte,
  input  logic                          in_restart,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [spk_pkg::BYTE_W-1:0]    out_result_byte
);
  import spk_pkg::*;

  queue_status_t q_status;
  logic          q_push;
  logic          q_pop;
  item_t         push_item;
  item_t         head_item;
  key_t          key;

  spk_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data_byte (in_data_byte),
    .in_restart   (in_restart),
    .q_status     (q_status),
    .q_push       (q_push),
    .q_item       (push_item),
    .key          (key)
  );

  spk_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .pop       (q_pop),
    .head_item (head_item),
    .status    (q_status)
  );

  spk_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .key             (key),
    .q_status        (q_status),
    .q_item          (head_item),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_result_byte (out_result_byte)
  );

endmodule

### tb/tb_speck64_ofb_stream_xor_core.sv
`timescale 1ns / 1ps
module tb_speck64_ofb_stream_xor_core;
  import spk_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    logic [BYTE_W-1:0] data;
    logic              restart;
  } beat_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = KEY_WORD_0;
  logic [WORD_W-1:0]    cfg_wdata = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [BYTE_W-1:0]    in_data_byte = '0;
  logic                 in_restart = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [BYTE_W-1:0]    out_result_byte;

  // Keystream mirror: key words, round keys, feedback block, byte position
  word_t                key_mirror [4];
  word_t                round_keys [ROUNDS];
  logic [63:0]          ofb_block = '0;
  logic [POS_W-1:0]     ks_pos = '0;

  beat_t                pending_beats [$];
  logic [BYTE_W-1:0]    expected_bytes [$];
  beat_t                next_beat;
  logic [BYTE_W-1:0]    want_byte;
  bit                   idle_enable = 1'b1;
  int                   gap_left = 0;
  int                   stall_left = 0;
  int                   err_count = 0;
  int                   cycle_count = 0;

  speck64_ofb_stream_xor_core u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data_byte    (in_data_byte),
    .in_restart      (in_restart),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_result_byte (out_result_byte)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    for (int i = 0; i < 4; i++) key_mirror[i] = '0;
    for (int i = 0; i < ROUNDS; i++) round_keys[i] = '0;
  end

  // Advance the keystream by one byte and return the combined byte
  function automatic logic [BYTE_W-1:0] keystream_xor(input logic [BYTE_W-1:0] d,
                                                      input logic rs);
    word_t lw [3];
    word_t k;
    word_t x;
    word_t y;
    int    r;
    if (rs) begin
      k = key_mirror[0];
      lw[0] = key_mirror[1];
      lw[1] = key_mirror[2];
      lw[2] = key_mirror[3];
      round_keys[0] = k;
      for (r = 0; r < ROUNDS - 1; r++) begin
        lw[r % 3] = (((lw[r % 3] >> 8) | (lw[r % 3] << 24)) + k) ^ word_t'(r);
        k = ((k << 3) | (k >> 29)) ^ lw[r % 3];
        round_keys[r + 1] = k;
      end
      ofb_block = {key_mirror[1] ^ key_mirror[3], key_mirror[0] ^ key_mirror[2]};
      ks_pos = '0;
    end
    if (ks_pos == '0) begin
      y = ofb_block[31:0];
      x = ofb_block[63:32];
      for (r = 0; r < ROUNDS; r++) begin
        x = (((x >> 8) | (x << 24)) + y) ^ round_keys[r];
        y = ((y << 3) | (y >> 29)) ^ x;
      end
      ofb_block = {x, y};
    end
    keystream_xor = d ^ ofb_block[int'(ks_pos) * 8 +: 8];
    ks_pos = ks_pos + POS_W'(1);
  endfunction

  function automatic void note_error(input string msg);
    if (err_count < 10) $display("%s", msg);
    err_count++;
  endfunction

  // Input driver: predict on each accepted beat, then present the next one
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall)
        expected_bytes.push_back(keystream_xor(in_data_byte, in_restart));
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (idle_enable && $urandom_range(0, 5) == 0) begin
          gap_left = $urandom_range(1, 10) - 1;
          in_valid <= 1'b0;
        end else if (pending_beats.size() != 0) begin
          next_beat = pending_beats.pop_front();
          in_valid <= 1'b1;
          in_data_byte <= next_beat.data;
          in_restart <= next_beat.restart;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: check each accepted beat, stall in random bursts
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_bytes.size() == 0) begin
          note_error($sformatf("unexpected result byte %02h", out_result_byte));
        end else begin
          want_byte = expected_bytes.pop_front();
          if (out_result_byte !== want_byte)
            note_error($sformatf("result_byte mismatch: expected %02h actual %02h",
                                 want_byte, out_result_byte));
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (idle_enable && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 10) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Hang guard
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_speck64_ofb_stream_xor_core: FAIL");
      $finish;
    end
  end

  task automatic write_reg(input cfg_reg_t idx, input word_t val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    key_mirror[idx] = val;
  endtask

  task automatic set_key(input word_t w0, input word_t w1, input word_t w2, input word_t w3);
    write_reg(KEY_WORD_0, w0);
    write_reg(KEY_WORD_1, w1);
    write_reg(KEY_WORD_2, w2);
    write_reg(KEY_WORD_3, w3);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic push_beat(input logic [BYTE_W-1:0] d, input logic rs);
    beat_t b;
    b.data = d;
    b.restart = rs;
    pending_beats.push_back(b);
  endtask

  // Hold until every queued beat has gone in and every result has come out
  task automatic drain();
    do @(posedge clk);
    while (pending_beats.size() != 0 || in_valid || expected_bytes.size() != 0);
  endtask

  // Random buffers; optionally carry on the running stream first
  task automatic random_phase(input int n_items, input bit keep_stream);
    int cnt;
    int len;
    cnt = 0;
    if (keep_stream) begin
      len = $urandom_range(1, 20);
      for (int i = 0; i < len; i++) push_beat(BYTE_W'($urandom_range(0, 255)), 1'b0);
      cnt = len;
    end
    while (cnt < n_items) begin
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(41, 120) : $urandom_range(1, 40);
      push_beat(BYTE_W'($urandom_range(0, 255)), 1'b1);
      for (int i = 1; i < len; i++) push_beat(BYTE_W'($urandom_range(0, 255)), 1'b0);
      cnt += len;
    end
    drain();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: zero key, byte extremes, block wrap, restart mid-block and back to back
    set_key('0, '0, '0, '0);
    push_beat(8'h00, 1'b1);
    push_beat(8'hFF, 1'b0);
    push_beat(8'h80, 1'b0);
    push_beat(8'h01, 1'b0);
    push_beat(8'h7F, 1'b0);
    push_beat(8'hFE, 1'b0);
    push_beat(8'hAA, 1'b0);
    push_beat(8'h55, 1'b0);
    push_beat(8'h00, 1'b0);
    push_beat(8'hFF, 1'b0);
    push_beat(8'h5A, 1'b1);
    push_beat(8'hC3, 1'b0);
    push_beat(8'hFF, 1'b1);
    push_beat(8'h00, 1'b1);
    drain();

    // Key change mid-buffer must not disturb the stream until the next restart
    set_key('1, '1, '1, '1);
    push_beat(8'h3C, 1'b0);
    push_beat(8'hC3, 1'b0);
    push_beat(8'h0F, 1'b0);
    push_beat(8'hF0, 1'b0);
    push_beat(8'h11, 1'b1);
    push_beat(8'hEE, 1'b0);
    push_beat(8'h99, 1'b0);
    drain();

    // Random buffers over several keys
    random_phase(130, 1'b0);
    set_key(32'h03020100, 32'h0b0a0908, 32'h13121110, 32'h1b1a1918);
    random_phase(130, 1'b1);
    set_key($urandom, $urandom, $urandom, $urandom);
    random_phase(130, 1'b0);
    idle_enable = 1'b0;
    set_key($urandom, $urandom, $urandom, $urandom);
    random_phase(130, 1'b1);
    idle_enable = 1'b1;
    set_key(32'hAAAAAAAA, 32'h55555555, 32'hAAAAAAAA, 32'h55555555);
    random_phase(130, 1'b0);
    set_key('0, '0, '0, '0);
    random_phase(130, 1'b1);
    set_key($urandom, $urandom, $urandom, $urandom);
    random_phase(130, 1'b0);

    // Final stretch without idling on either side
    idle_enable = 1'b0;
    set_key($urandom, $urandom, $urandom, $urandom);
    random_phase(130, 1'b0);

    repeat (40) @(posedge clk);
    if (err_count == 0 && expected_bytes.size() == 0) begin
      $display("tb_speck64_ofb_stream_xor_core: PASS");
    end else begin
      $display("tb_speck64_ofb_stream_xor_core: FAIL");
    end
    $finish;
  end

endmodule

### sim.f
src/spk_pkg.sv
src/spk_front.sv
src/spk_queue.sv
src/spk_back.sv
src/speck64_ofb_stream_xor_core.sv
tb/tb_speck64_ofb_stream_xor_core.sv
